// ===== design/mlc_pkg.sv =====
package mlc_pkg;

  // Longest code that decodes to a letter; a longer run is an error.
  localparam int MaxCodeLen = 4;
  // Stored symbols of a code, and the width of the code length counter.
  localparam int PatW   = 4;
  localparam int LenW   = 3;
  localparam int NumLetters = 26;

  localparam logic [7:0] CharDot  = 8'h2E;
  localparam logic [7:0] CharDash = 8'h2D;
  localparam logic [7:0] CharA    = 8'h61;
  localparam logic [7:0] CharZ    = 8'h7A;

  typedef enum logic [1:0] {
    SymDot  = 2'd0,
    SymDash = 2'd1,
    SymGap  = 2'd2
  } symbol_e;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [PatW-1:0] bits;
  } code_t;

  // One pending item for the result stage.
  typedef struct packed {
    logic            dec;     // decode result, single transfer
    logic [LenW-1:0] cnt;     // encode symbols still to send before the gap
    logic [PatW-1:0] bits;    // encode symbols, next one in bit 0
    logic [6:0]      letter;
    logic            status;
  } job_t;

  // Code of each letter; bit i is symbol i, 1 is a dash.
  function automatic code_t code_entry(input logic [4:0] idx);
    code_t c;
    case (idx)
      5'd0:  c = '{3'd2, 4'h2};
      5'd1:  c = '{3'd4, 4'h1};
      5'd2:  c = '{3'd4, 4'h5};
      5'd3:  c = '{3'd3, 4'h1};
      5'd4:  c = '{3'd1, 4'h0};
      5'd5:  c = '{3'd4, 4'h4};
      5'd6:  c = '{3'd3, 4'h3};
      5'd7:  c = '{3'd4, 4'h0};
      5'd8:  c = '{3'd2, 4'h0};
      5'd9:  c = '{3'd4, 4'hE};
      5'd10: c = '{3'd3, 4'h5};
      5'd11: c = '{3'd4, 4'h2};
      5'd12: c = '{3'd2, 4'h3};
      5'd13: c = '{3'd2, 4'h1};
      5'd14: c = '{3'd3, 4'h7};
      5'd15: c = '{3'd4, 4'h6};
      5'd16: c = '{3'd4, 4'hB};
      5'd17: c = '{3'd3, 4'h2};
      5'd18: c = '{3'd3, 4'h0};
      5'd19: c = '{3'd1, 4'h1};
      5'd20: c = '{3'd3, 4'h4};
      5'd21: c = '{3'd4, 4'h8};
      5'd22: c = '{3'd3, 4'h6};
      5'd23: c = '{3'd4, 4'h9};
      5'd24: c = '{3'd4, 4'hD};
      5'd25: c = '{3'd4, 4'h3};
      default: c = '{3'd0, 4'h0};
    endcase
    return c;
  endfunction

  // Letter for a collected code, 0 when no letter has that code.
  function automatic logic [6:0] code_letter(input logic [LenW-1:0] len,
                                             input logic [PatW-1:0] bits);
    logic [6:0] l;
    code_t      c;
    l = '0;
    for (int i = 0; i < NumLetters; i++) begin
      c = code_entry(5'(i));
      if (c.len == len && c.bits == bits) begin
        l = CharA[6:0] + 7'(i);
      end
    end
    return l;
  endfunction

endpackage

// ===== design/mlc_emit.sv =====
module mlc_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_load_i,
  input  mlc_pkg::job_t   job_i,
  output logic            job_busy_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      out_symbol_o,
  output logic [6:0]      out_letter_o,
  output logic            out_status_o,
  output logic            out_last_o
);

  logic          job_vld_q, job_vld_d;
  mlc_pkg::job_t job_q, job_d;
  logic          out_vld_q, out_vld_d;
  logic [1:0]    sym_q, sym_d;
  logic [6:0]    letter_q, letter_d;
  logic          status_q, status_d;
  logic          last_q, last_d;

  logic          out_free;
  logic          take;
  logic          res_last;
  logic          job_done;

  assign out_free = !out_vld_q || !out_stall_i;
  assign take     = job_vld_q && out_free;
  assign res_last = job_q.dec || (job_q.cnt == '0);
  assign job_done = take && res_last;

  assign job_busy_o = job_vld_q && !job_done;

  always_comb begin
    job_vld_d = job_vld_q;
    job_d     = job_q;
    if (job_load_i) begin
      job_vld_d = 1'b1;
      job_d     = job_i;
    end else if (job_done) begin
      job_vld_d = 1'b0;
    end else if (take) begin
      job_d.cnt  = job_q.cnt - 1'b1;
      job_d.bits = job_q.bits >> 1;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    sym_d     = sym_q;
    letter_d  = letter_q;
    status_d  = status_q;
    last_d    = last_q;
    if (take) begin
      out_vld_d = 1'b1;
      last_d    = res_last;
      if (job_q.dec) begin
        sym_d    = mlc_pkg::SymDot;
        letter_d = job_q.letter;
        status_d = job_q.status;
      end else begin
        letter_d = '0;
        status_d = 1'b0;
        if (job_q.cnt == '0) begin
          sym_d = mlc_pkg::SymGap;
        end else if (job_q.bits[0]) begin
          sym_d = mlc_pkg::SymDash;
        end else begin
          sym_d = mlc_pkg::SymDot;
        end
      end
    end else if (out_free) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      job_vld_q <= job_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    sym_q    <= sym_d;
    letter_q <= letter_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = out_vld_q;
  assign out_symbol_o = sym_q;
  assign out_letter_o = letter_q;
  assign out_status_o = status_q;
  assign out_last_o   = last_q;

`ifndef SYNTHESIS
  a_no_job_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_load_i |-> (!job_vld_q || job_done))
    else $error("job loaded while previous job still pending");

  a_enc_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_vld_q && !job_q.dec) |-> (job_q.cnt <= 3'(mlc_pkg::PatW)))
    else $error("encode symbol count out of range");

  a_gap_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && sym_q == mlc_pkg::SymGap) |-> last_q)
    else $error("gap symbol without last flag");

  a_job_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_done && !job_load_i) |=> !job_vld_q)
    else $error("job still pending after its last transfer");
`endif

endmodule

// ===== design/morse_letter_codec_unit.sv =====
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_we_i                  cfg_wdata_i (decode_mode)
// in        in         in_valid_i / in_stall_o   in_char_i
// out       out        out_valid_o / out_stall_i out_symbol_o, out_letter_o,
//                                                out_status_o, out_last_o
//
// An item that yields one result or none does not hold up the input; a letter in
// encode mode yields its code length plus one gap, so 2 to 5 results, one output
// transfer a cycle while out_stall_i is low. A single job register ahead of the
// output register lets the next item in as the current job sends its last result.
// Reset clears the mode (encode), the collected code and both valid flags.
// A stalled output holds its result; the job register then holds, and in_stall_o
// rises until the job's last result can move.
module morse_letter_codec_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_symbol_o,
  output logic [6:0] out_letter_o,
  output logic       out_status_o,
  output logic       out_last_o
);

  logic                     mode_q;
  logic [mlc_pkg::PatW-1:0] pat_q, pat_d;
  logic [mlc_pkg::LenW-1:0] len_q, len_d;

  logic          in_acc;
  logic          job_busy;
  logic          job_load;
  mlc_pkg::job_t job;
  logic          is_sym;
  logic          is_letter;
  logic [4:0]    letter_off;
  mlc_pkg::code_t enc_code;
  logic [6:0]    dec_letter;
  logic          code_ok;

  assign in_stall_o = job_busy;
  assign in_acc     = in_valid_i && !job_busy;

  // Classify the incoming character.
  assign is_sym     = (in_char_i == mlc_pkg::CharDot) || (in_char_i == mlc_pkg::CharDash);
  assign is_letter  = (in_char_i >= mlc_pkg::CharA) && (in_char_i <= mlc_pkg::CharZ);
  assign letter_off = in_char_i[4:0] - mlc_pkg::CharA[4:0];
  assign enc_code   = mlc_pkg::code_entry(letter_off);

  // Decode lookup on the code collected so far.
  assign dec_letter = mlc_pkg::code_letter(len_q, pat_q);
  assign code_ok    = (len_q != '0) && (len_q <= mlc_pkg::LenW'(mlc_pkg::MaxCodeLen))
                      && (dec_letter != '0);

  // Build the job for this transfer; only letters (encode) and
  // separators (decode) produce results.
  always_comb begin
    job.dec    = mode_q;
    job.cnt    = enc_code.len;
    job.bits   = enc_code.bits;
    job.letter = code_ok ? dec_letter : '0;
    job.status = !code_ok;
    job_load   = in_acc && (mode_q ? !is_sym : is_letter);
  end

  // Collect dots and dashes; a separator empties the code.
  always_comb begin
    pat_d = pat_q;
    len_d = len_q;
    if (in_acc && mode_q) begin
      if (is_sym) begin
        if (len_q < mlc_pkg::LenW'(mlc_pkg::PatW) && in_char_i == mlc_pkg::CharDash) begin
          pat_d[len_q[1:0]] = 1'b1;
        end
        // Saturate one past the longest code to mark an over-long run.
        if (len_q <= mlc_pkg::LenW'(mlc_pkg::MaxCodeLen)) begin
          len_d = len_q + 1'b1;
        end
      end else begin
        pat_d = '0;
        len_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      pat_q  <= '0;
      len_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      pat_q <= pat_d;
      len_q <= len_d;
    end
  end

  // Serialize each job into output transfers.
  mlc_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_load_i   (job_load),
    .job_i        (job),
    .job_busy_o   (job_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_symbol_o (out_symbol_o),
    .out_letter_o (out_letter_o),
    .out_status_o (out_status_o),
    .out_last_o   (out_last_o)
  );

endmodule

// ===== bench/morse_letter_codec_checker.sv =====
`timescale 1ns / 100ps

module morse_letter_codec_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_char_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] out_symbol_i,
  input  logic [6:0] out_letter_i,
  input  logic       out_status_i,
  input  logic       out_last_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         results_o
);

  typedef struct {
    mlc_pkg::symbol_e sym;
    logic [6:0]       letter;
    logic             status;
    logic             last;
  } morse_result_t;

  morse_result_t            expected_q[$];
  logic                     decode_sel;
  logic [mlc_pkg::PatW-1:0] code_pat;
  logic [mlc_pkg::LenW-1:0] code_len;
  int                       fails   = 0;
  int                       results = 0;

  // Dots and dashes of each letter, written out as text.
  function automatic string morse_text(input int idx);
    case (idx)
      0:  return ".-";
      1:  return "-...";
      2:  return "-.-.";
      3:  return "-..";
      4:  return ".";
      5:  return "..-.";
      6:  return "--.";
      7:  return "....";
      8:  return "..";
      9:  return ".---";
      10: return "-.-";
      11: return ".-..";
      12: return "--";
      13: return "-.";
      14: return "---";
      15: return ".--.";
      16: return "--.-";
      17: return ".-.";
      18: return "...";
      19: return "-";
      20: return "..-";
      21: return "...-";
      22: return ".--";
      23: return "-..-";
      24: return "-.--";
      default: return "--..";
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fails++;
    $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    morse_result_t            want;
    string                    txt;
    logic [6:0]               hit;
    logic                     err;
    logic [mlc_pkg::PatW-1:0] pat;
    if (!rst_ni) begin
      decode_sel = 1'b0;
      code_pat   = '0;
      code_len   = '0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      // Compare each output transfer with the oldest expectation.
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected, symbol", out_symbol_i, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_symbol_i !== want.sym)
            report_mismatch("symbol", out_symbol_i, want.sym);
          if (out_letter_i !== want.letter)
            report_mismatch("letter", out_letter_i, want.letter);
          if (out_status_i !== want.status)
            report_mismatch("status", out_status_i, want.status);
          if (out_last_i !== want.last)
            report_mismatch("last", out_last_i, want.last);
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (!decode_sel) begin
          // Encode: letters only, symbols then the gap.
          if (in_char_i >= mlc_pkg::CharA && in_char_i <= mlc_pkg::CharZ) begin
            txt = morse_text(int'(in_char_i - mlc_pkg::CharA));
            for (int i = 0; i < txt.len(); i++) begin
              expected_q.push_back('{(txt[i] == mlc_pkg::CharDash) ? mlc_pkg::SymDash
                                                                   : mlc_pkg::SymDot,
                                     7'd0, 1'b0, 1'b0});
            end
            expected_q.push_back('{mlc_pkg::SymGap, 7'd0, 1'b0, 1'b1});
          end
        end else if (in_char_i == mlc_pkg::CharDot || in_char_i == mlc_pkg::CharDash) begin
          // Collect; keep only the first four symbols, saturate the length.
          if (code_len < mlc_pkg::PatW && in_char_i == mlc_pkg::CharDash)
            code_pat[code_len[1:0]] = 1'b1;
          if (code_len <= mlc_pkg::MaxCodeLen) code_len = code_len + 1'b1;
        end else begin
          // Separator: look the code up, then clear it.
          hit = '0;
          err = 1'b1;
          if (code_len != 0 && code_len <= mlc_pkg::MaxCodeLen) begin
            for (int l = 0; l < mlc_pkg::NumLetters; l++) begin
              txt = morse_text(l);
              pat = '0;
              for (int i = 0; i < txt.len(); i++) pat[i] = (txt[i] == mlc_pkg::CharDash);
              if (err && txt.len() == code_len && pat == code_pat) begin
                hit = mlc_pkg::CharA[6:0] + 7'(l);
                err = 1'b0;
              end
            end
          end
          expected_q.push_back('{mlc_pkg::SymDot, hit, err, 1'b1});
          code_pat = '0;
          code_len = '0;
        end
      end

      // A mode write takes effect for the items after this edge.
      if (cfg_we_i) decode_sel = cfg_wdata_i;

      pending_o    <= expected_q.size();
      fail_count_o <= fails;
      results_o    <= results;
    end
  end

endmodule

// ===== bench/morse_letter_codec_unit_tb.sv =====
`timescale 1ns / 100ps

module morse_letter_codec_unit_tb;

  // Generous bound; the slowest legal run stays far below it.
  localparam int CycleLimit = 300000;
  // Cycles the block may still spend on an item that yields nothing.
  localparam int SettleCycles = 8;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_char_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] out_symbol_o;
  logic [6:0] out_letter_o;
  logic       out_status_o;
  logic       out_last_o;

  int fail_count;
  int pending;
  int results;
  int cycle_cnt  = 0;
  int chars_sent = 0;
  int cfg_writes = 0;
  int stall_left = 0;
  bit calm       = 1'b0;

  always #6 clk_i = ~clk_i;

  morse_letter_codec_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_char_i   (in_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_symbol_o(out_symbol_o),
    .out_letter_o(out_letter_o),
    .out_status_o(out_status_o),
    .out_last_o  (out_last_o)
  );

  morse_letter_codec_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_char_i   (in_char_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_symbol_i(out_symbol_o),
    .out_letter_i(out_letter_o),
    .out_status_i(out_status_o),
    .out_last_i  (out_last_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results)
  );

  // Receiver: after each output transfer draw a random stall, none while calm.
  // The countdown also runs while no result is offered, so stalls land on
  // every phase of the block's work.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) stall_left = calm ? 0 : $urandom_range(0, 6);
    else if (stall_left != 0) stall_left--;
    out_stall_i <= (stall_left != 0);
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout with %0d results still expected", pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one character after a random gap and hold it until the transfer.
  // Keep valid high across back-to-back items; drop it only for a gap.
  task automatic send_char(input logic [7:0] c);
    int gap;
    calm = (chars_sent % 50) >= 40;
    gap  = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_char_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) send_char(t[i]);
  endtask

  // Stop sending, wait for every expected result, then let the block settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the mode register; only called with the block idle.
  task automatic set_mode(input logic decode);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= decode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int         letters;
    int         codes;
    int         kind;
    int         n;
    logic [7:0] c;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed encode: extreme letters, single-symbol and four-symbol codes,
    // and non-letters on both sides of the letter range, which yield nothing.
    set_mode(1'b0);
    send_text("azesq");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h60);
    send_char(8'h7B);
    wait_drained();

    // Directed decode: empty code, known codes with various separators,
    // an over-long code and an unknown four-symbol code.
    set_mode(1'b1);
    send_text(" ");
    send_text(".- ");
    send_text("--..");
    send_char(8'hFF);
    send_text("...");
    send_char(8'h00);
    send_text("...../");
    send_text("---. ");
    // A collected code survives a trip through encode mode.
    send_text("-");
    wait_drained();
    set_mode(1'b0);
    send_text("e");
    wait_drained();
    set_mode(1'b1);
    send_text(".,");
    wait_drained();

    // Random part: alternate the modes, two phases each.
    for (int phase = 0; phase < 4; phase++) begin
      set_mode(phase[0]);
      if (!phase[0]) begin
        // Mostly letters, some arbitrary bytes; only letters count.
        letters = 0;
        while (letters < 45) begin
          if ($urandom_range(0, 9) < 8) c = mlc_pkg::CharA + 8'($urandom_range(0, 25));
          else c = 8'($urandom_range(0, 255));
          if (c >= mlc_pkg::CharA && c <= mlc_pkg::CharZ) letters++;
          send_char(c);
          // Hold off until the output side has caught up, for each character sent while 22 letters are counted.
          if (phase == 0 && letters == 22) wait_drained();
        end
      end else begin
        // Mostly well-formed codes closed by a separator, plus noise.
        codes = 0;
        while (codes < 30) begin
          kind = $urandom_range(0, 9);
          if (kind <= 7) begin
            if (kind <= 4) begin
              send_text(u_checker.morse_text($urandom_range(0, mlc_pkg::NumLetters - 1)));
            end else begin
              n = (kind == 7) ? $urandom_range(0, 7) : $urandom_range(1, 4);
              repeat (n) send_char($urandom_range(0, 1) ? mlc_pkg::CharDash : mlc_pkg::CharDot);
            end
            do c = 8'($urandom_range(0, 255));
            while (c == mlc_pkg::CharDot || c == mlc_pkg::CharDash);
            send_char($urandom_range(0, 2) == 0 ? c : 8'h20);
            codes++;
          end else begin
            send_char(8'($urandom_range(0, 255)));
          end
        end
      end
      wait_drained();
    end

    $display("sent %0d characters over %0d mode writes in both modes", chars_sent,
             cfg_writes);
    $display("checked %0d results, %0d mismatches", results, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
